/* design/priority_level_interrupt_controller_top_macros.svh */
// Assertion macros for the priority level interrupt controller.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PRIORITY_LEVEL_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define PRIORITY_LEVEL_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PLIC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PLIC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PLIC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PLIC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/plic_pkg.sv */
// Package of the priority level interrupt controller: word types, command
// codes and the lowest-set-bit function. Depends on nothing.
package plic_pkg;

   localparam int WORD_BITS = 32;
   localparam int LEVEL_W   = 4;
   localparam int VECTOR_W  = 6;
   localparam int BIT_W     = 5;

   localparam logic [1:0] CMD_UNMASK  = 2'd0;
   localparam logic [1:0] CMD_MASK    = 2'd1;
   localparam logic [1:0] CMD_SERVICE = 2'd2;
   localparam logic [1:0] CMD_END     = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [VECTOR_W-1:0]  vector;
      logic [LEVEL_W-1:0]   level;
      logic [WORD_BITS-1:0] pending_lo;
      logic [WORD_BITS-1:0] pending_hi;
   } req_word_type;

   typedef struct packed {
      logic                 taken;
      logic [VECTOR_W-1:0]  chosen_vector;
      logic [LEVEL_W-1:0]   level_now;
      logic [WORD_BITS-1:0] level_enable_lo;
      logic [WORD_BITS-1:0] level_enable_hi;
      logic [WORD_BITS-1:0] source_enable_lo;
   } rsp_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   level;
      logic [WORD_BITS-1:0] bits;
   } stack_entry_type;

   typedef struct packed {
      logic load_item;
      logic execute;
      logic load_out;
   } ctrl_cmd_type;

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* design/plic_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module plic_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/plic_ctrl.sv */
// Controller of the priority level interrupt controller: sequences capture,
// execution and result loading. Depends on plic_pkg.
module plic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output plic_pkg::ctrl_cmd_type cmd
);
   import plic_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/plic_dp.sv */
// Datapath of the priority level interrupt controller: vector levels,
// current level, nesting stack and the result register.
// Depends on plic_pkg, plic_ram and the assertion macro header.
`include "priority_level_interrupt_controller_top_macros.svh"
module plic_dp #(
   parameter int NUM_VECTORS = 64,
   parameter int NUM_LEVELS  = 16,
   parameter int NEST_DEPTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  plic_pkg::ctrl_cmd_type cmd,
   input  plic_pkg::req_word_type req_data,
   output plic_pkg::rsp_word_type rsp_data
);
   import plic_pkg::*;

   localparam int VW = $clog2(NUM_VECTORS);
   localparam int DW = $clog2(NEST_DEPTH + 1);
   localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(NUM_LEVELS - 1);
   localparam logic [DW-1:0]      DEPTH_MAX = DW'(NEST_DEPTH);

   req_word_type          item_ff;
   logic [LEVEL_W-1:0]    vl_ff [NUM_VECTORS];
   logic [LEVEL_W-1:0]    vl_in [NUM_VECTORS];
   logic [LEVEL_W-1:0]    cur_ff, cur_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [WORD_BITS-1:0]  se_ff, se_in;
   logic                  taken_ff, taken_in;
   logic [VECTOR_W-1:0]   chosen_ff, chosen_in;
   rsp_word_type          rsp_ff;

   logic [2*WORD_BITS-1:0] vmask;
   logic [2*WORD_BITS-1:0] en;
   logic [WORD_BITS-1:0]   plo, phi, disabled;
   logic [LEVEL_W-1:0]     lvl_sat, ch_level;
   logic [VECTOR_W-1:0]    chosen;
   logic [DW-1:0]          depth_m1;
   logic                   vec_ok, use_lo, svc_ok, pop_ok;
   logic                   ram_wr_en, ram_rd_en;
   stack_entry_type        push_entry, pop_entry;

   for (genvar gi = 0; gi < 2 * WORD_BITS; gi++) begin : g_lane
      if (gi < NUM_VECTORS) begin : g_used
         assign vmask[gi] = 1'b1;
         assign en[gi]    = (vl_ff[gi] > cur_ff);
      end else begin : g_unused
         assign vmask[gi] = 1'b0;
         assign en[gi]    = 1'b0;
      end
   end

   assign plo      = item_ff.pending_lo & vmask[WORD_BITS-1:0];
   assign phi      = item_ff.pending_hi & vmask[2*WORD_BITS-1:WORD_BITS];
   assign lvl_sat  = (item_ff.level > LEVEL_MAX) ? LEVEL_MAX : item_ff.level;
   assign vec_ok   = ((VECTOR_W + 1)'(item_ff.vector) < (VECTOR_W + 1)'(NUM_VECTORS));
   assign use_lo   = (plo != '0);
   assign chosen   = use_lo ? {1'b0, lowest_bit(plo)} : {1'b1, lowest_bit(phi)};
   assign disabled = use_lo ? plo : '0;
   assign ch_level = vl_ff[chosen[VW-1:0]];
   assign svc_ok   = (item_ff.command == CMD_SERVICE) && (use_lo || (phi != '0))
                     && (depth_ff < DEPTH_MAX);
   assign pop_ok   = (item_ff.command == CMD_END) && (depth_ff != '0);
   assign depth_m1 = depth_ff - 1'b1;

   assign push_entry.level = cur_ff;
   assign push_entry.bits  = disabled;
   assign ram_wr_en = cmd.execute && svc_ok;
   assign ram_rd_en = cmd.load_item && (req_data.command == CMD_END) && (depth_ff != '0);

   plic_ram #(
      .WIDTH ($bits(stack_entry_type)),
      .DEPTH (NEST_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (push_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (depth_m1[AW-1:0]),
      .rd_data (pop_entry)
   );

   always_comb begin
      vl_in     = vl_ff;
      cur_in    = cur_ff;
      depth_in  = depth_ff;
      se_in     = se_ff;
      taken_in  = 1'b0;
      chosen_in = '0;
      case (item_ff.command)
         CMD_UNMASK: begin
            for (int i = 0; i < NUM_VECTORS; i++) begin
               if (vec_ok && (item_ff.vector[VW-1:0] == VW'(i))) begin
                  vl_in[i] = lvl_sat;
               end
            end
         end
         CMD_MASK: begin
            for (int i = 0; i < NUM_VECTORS; i++) begin
               if (vec_ok && (item_ff.vector[VW-1:0] == VW'(i))) begin
                  vl_in[i] = '0;
               end
            end
         end
         CMD_SERVICE: begin
            if (svc_ok) begin
               taken_in  = 1'b1;
               chosen_in = chosen;
               depth_in  = depth_ff + 1'b1;
               se_in     = se_ff & ~disabled;
               if (ch_level > cur_ff) begin
                  cur_in = ch_level;
               end
            end
         end
         CMD_END: begin
            if (pop_ok) begin
               depth_in = depth_m1;
               cur_in   = pop_entry.level;
               se_in    = se_ff | pop_entry.bits;
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VECTORS; i++) begin
            vl_ff[i] <= '0;
         end
         cur_ff   <= '0;
         depth_ff <= '0;
         se_ff    <= '0;
      end else if (cmd.execute) begin
         vl_ff    <= vl_in;
         cur_ff   <= cur_in;
         depth_ff <= depth_in;
         se_ff    <= se_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.execute) begin
         taken_ff  <= taken_in;
         chosen_ff <= chosen_in;
      end
      if (cmd.load_out) begin
         rsp_ff.taken            <= taken_ff;
         rsp_ff.chosen_vector    <= chosen_ff;
         rsp_ff.level_now        <= cur_ff;
         rsp_ff.level_enable_lo  <= en[WORD_BITS-1:0];
         rsp_ff.level_enable_hi  <= en[2*WORD_BITS-1:WORD_BITS];
         rsp_ff.source_enable_lo <= se_ff;
      end
   end

   assign rsp_data = rsp_ff;

   `PLIC_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_MAX, "nest depth beyond the stack size")
   `PLIC_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, cur_ff <= LEVEL_MAX, "current level beyond the top level")
   `PLIC_ASSERT_NXT(a_push_depth, clock, reset, cmd.execute && svc_ok, depth_ff == $past(depth_ff) + 1'b1, "service did not push")
   `PLIC_ASSERT_NXT(a_service_level, clock, reset, cmd.execute && svc_ok, cur_ff >= $past(cur_ff), "service lowered the current level")

endmodule

/* design/priority_level_interrupt_controller_top.sv */
// Nesting interrupt priority level controller, top level.
// A request word passes through the capture, execute and result-load sequence of the
// controller, and a new word is taken only once the result of the last one is loaded;
// a stalled result holds the sequence in its last step.
// Reset is synchronous and clears all vector levels, the current level, the nesting
// depth and the source enables at once; stack entries are undefined until pushed.
module priority_level_interrupt_controller_top #(
   parameter int NUM_VECTORS = 64,
   parameter int NUM_LEVELS  = 16,
   parameter int NEST_DEPTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  plic_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output plic_pkg::rsp_word_type rsp_data
);
   import plic_pkg::*;

   ctrl_cmd_type cmd;

   plic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   plic_dp #(
      .NUM_VECTORS (NUM_VECTORS),
      .NUM_LEVELS  (NUM_LEVELS),
      .NEST_DEPTH  (NEST_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
